// ----- rtl/core/lfu_pkg.sv -----
// Shared types and constants for the LFU cache table.
// No dependencies.
`timescale 1ns / 1ps
package lfu_pkg;
   localparam int CAPACITY   = 16;
   localparam int COUNT_BITS = 16;
   localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OCC_BITS   = $clog2(CAPACITY + 1);
   localparam int CFG_BITS   = 5;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   localparam logic [1:0] MODE_TOUCH   = 2'd0;
   localparam logic [1:0] MODE_COMPACT = 2'd1;
   localparam logic [1:0] MODE_INSERT  = 2'd2;

   typedef struct packed {
      logic [31:0]           key;
      logic [31:0]           value;
      logic [COUNT_BITS-1:0] count;
      logic [IDX_BITS-1:0]   rank;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FIND_RD, ST_FIND_CHK, ST_DECIDE, ST_VIC_RD, ST_VIC_CHK,
      ST_EVICT, ST_AGE_RD, ST_AGE_WR, ST_FINAL, ST_RESP
   } state_type;
endpackage

// ----- rtl/core/lfu_entry_ram.sv -----
// Entry store of the LFU cache table: one synchronous RAM, one port.
// Depends on lfu_pkg.
`timescale 1ns / 1ps
module lfu_entry_ram
   import lfu_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_BITS-1:0] addr,
   input  entry_type           wr_data,
   output entry_type           rd_data
);
   entry_type mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ----- rtl/core/lfu_cache_table.sv -----
// Top level of the LFU cache table: sequencer around the entry RAM.
// Depends on lfu_pkg and lfu_entry_ram.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low. Exactly one result
// beat follows, shown for one cycle with rsp_valid; the receiver cannot stall.
// Each request walks the entry RAM one entry at a time, a read state and then
// a check or write state for each: a key search, on a put of a new key into
// a full cache a victim search, and passes that age or compact recency ranks
// (an eviction needs a compacting pass and an ageing pass). A get miss or a
// put while the capacity is zero answers after the key search; a get hit, an
// update or an insert with room adds one rank pass and a final write; an
// insert with eviction adds the victim search, both passes and the write.
// busy falls in the cycle that shows the result, so a new request may be
// taken then. The single RAM port is why the entries are walked one at a
// time. Valid bits sit in flip-flops, so reset empties the cache at once;
// the capacity register resets to 16 and is written through the csr_
// channel, always ready.
module lfu_cache_table
   import lfu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_type,
   input  logic [31:0]         req_key,
   input  logic signed [31:0]  req_value,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CFG_BITS-1:0] csr_data,
   output logic                rsp_valid,
   output logic                rsp_hit,
   output logic signed [31:0]  rsp_read_value
);
   state_type state_ff, state_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [CFG_BITS-1:0] cap_ff;
   logic [OCC_BITS-1:0] occ_ff, occ_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in, slot_ff, slot_in;
   logic                last_ff, last_in, found_ff, found_in, vhave_ff, vhave_in;
   logic                type_ff;
   logic [31:0]         key_ff, value_ff;
   logic [COUNT_BITS-1:0] vcnt_ff, vcnt_in;
   logic [IDX_BITS-1:0] vrank_ff, vrank_in, orank_ff, orank_in;
   logic [1:0]          mode_ff, mode_in;
   logic                hit_ff, hit_in, rv_ff, rv_in;
   logic [31:0]         rval_ff, rval_in;
   logic                wr_en;
   logic [IDX_BITS-1:0] addr;
   entry_type           wr_data, rd_data;
   logic [OCC_BITS:0]   limit;
   logic                cap_big;

   lfu_entry_ram u_ram (.clock(clock), .wr_en(wr_en), .addr(addr),
                        .wr_data(wr_data), .rd_data(rd_data));

   assign csr_ready = 1'b1;
   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_hit = hit_ff;
   assign rsp_read_value = rval_ff;
   assign cap_big = ({{(32-CFG_BITS){1'b0}}, cap_ff} > 32'(CAPACITY));
   assign limit = cap_big ? (OCC_BITS+1)'(CAPACITY) : (OCC_BITS+1)'(cap_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         occ_ff <= '0;
         cap_ff <= CFG_BITS'(16);
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         occ_ff <= occ_in;
         rv_ff <= rv_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
      end
      if (start && !busy) begin
         type_ff <= req_type;
         key_ff <= req_key;
         value_ff <= req_value;
      end
      idx_ff <= idx_in;     slot_ff <= slot_in;   last_ff <= last_in;
      found_ff <= found_in; vhave_ff <= vhave_in; vcnt_ff <= vcnt_in;
      vrank_ff <= vrank_in; orank_ff <= orank_in; mode_ff <= mode_in;
      hit_ff <= hit_in;     rval_ff <= rval_in;
   end

   always_comb begin
      state_in = state_ff; valid_in = valid_ff; occ_in = occ_ff;
      idx_in = idx_ff; slot_in = slot_ff; last_in = last_ff;
      found_in = found_ff; vhave_in = vhave_ff; vcnt_in = vcnt_ff;
      vrank_in = vrank_ff; orank_in = orank_ff; mode_in = mode_ff;
      hit_in = hit_ff; rval_in = rval_ff; rv_in = 1'b0;
      wr_en = 1'b0; addr = idx_ff; wr_data = rd_data;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               idx_in = '0; found_in = 1'b0; state_in = ST_FIND_RD;
            end
         end
         ST_FIND_RD: begin
            state_in = ST_FIND_CHK;
         end
         ST_FIND_CHK: begin
            if (valid_ff[idx_ff] && rd_data.key == key_ff && !found_ff) begin
               found_in = 1'b1; slot_in = idx_ff; orank_in = rd_data.rank;
               rval_in = rd_data.value;
            end
            if (idx_ff == IDX_BITS'(CAPACITY-1)) begin
               state_in = ST_DECIDE;
            end else begin
               idx_in = idx_ff + 1'b1; state_in = ST_FIND_RD;
            end
         end
         ST_DECIDE: begin
            hit_in = found_ff; idx_in = '0; vhave_in = 1'b0;
            if (type_ff == REQ_GET) begin
               if (!found_ff) rval_in = '0;
               mode_in = MODE_TOUCH;
               state_in = found_ff ? ST_AGE_RD : ST_RESP;
            end else if (limit == '0) begin
               hit_in = 1'b0; rval_in = '0; state_in = ST_RESP;
            end else if (found_ff) begin
               rval_in = '0; mode_in = MODE_TOUCH; state_in = ST_AGE_RD;
            end else begin
               rval_in = '0;
               state_in = ({1'b0, occ_ff} >= limit) ? ST_VIC_RD : ST_AGE_RD;
               mode_in = MODE_INSERT;
            end
         end
         ST_VIC_RD: begin
            state_in = ST_VIC_CHK;
         end
         ST_VIC_CHK: begin
            if (valid_ff[idx_ff] && (!vhave_ff || rd_data.count < vcnt_ff ||
                (rd_data.count == vcnt_ff && rd_data.rank > vrank_ff))) begin
               vhave_in = 1'b1; slot_in = idx_ff;
               vcnt_in = rd_data.count; vrank_in = rd_data.rank;
            end
            if (idx_ff == IDX_BITS'(CAPACITY-1)) begin
               state_in = ST_EVICT;
            end else begin
               idx_in = idx_ff + 1'b1; state_in = ST_VIC_RD;
            end
         end
         ST_EVICT: begin
            idx_in = '0;
            if (vhave_ff) begin
               valid_in[slot_ff] = 1'b0; occ_in = occ_ff - 1'b1;
               orank_in = vrank_ff; mode_in = MODE_COMPACT;
            end else begin
               mode_in = MODE_INSERT;
            end
            state_in = ST_AGE_RD;
         end
         ST_AGE_RD: begin
            state_in = ST_AGE_WR;
         end
         ST_AGE_WR: begin
            wr_data = rd_data;
            if (valid_ff[idx_ff]) begin
               case (mode_ff)
                  MODE_TOUCH: if (rd_data.rank < orank_ff) wr_data.rank = rd_data.rank + 1'b1;
                  MODE_COMPACT: if (rd_data.rank > orank_ff) wr_data.rank = rd_data.rank - 1'b1;
                  default: wr_data.rank = rd_data.rank + 1'b1;
               endcase
               wr_en = 1'b1;
            end
            if (idx_ff == IDX_BITS'(CAPACITY-1)) begin
               if (mode_ff == MODE_COMPACT) begin
                  idx_in = '0; mode_in = MODE_INSERT; state_in = ST_AGE_RD;
               end else begin
                  state_in = ST_FINAL;
                  if (mode_ff == MODE_TOUCH) begin
                     idx_in = slot_ff;
                  end else begin
                     found_in = 1'b0;
                     for (int i = CAPACITY-1; i >= 0; i--) begin
                        if (!valid_ff[i]) begin
                           idx_in = IDX_BITS'(i); found_in = 1'b1;
                        end
                     end
                  end
               end
            end else begin
               idx_in = idx_ff + 1'b1; state_in = ST_AGE_RD;
            end
         end
         ST_FINAL: begin
            state_in = ST_RESP;
            if (mode_ff == MODE_TOUCH) begin
               wr_en = 1'b1;
               wr_data = entry_type'(0);
               wr_data.key = key_ff;
               wr_data.value = (type_ff == REQ_PUT) ? value_ff : rval_ff;
               wr_data.rank = '0;
               wr_data.count = (vcnt_ff < COUNT_MAX) ? vcnt_ff + 1'b1 : vcnt_ff;
            end else if (found_ff) begin
               wr_en = 1'b1;
               wr_data.key = key_ff; wr_data.value = value_ff;
               wr_data.count = COUNT_BITS'(1); wr_data.rank = '0;
               valid_in[idx_ff] = 1'b1; occ_in = occ_ff + 1'b1;
            end
         end
         ST_RESP: begin
            rv_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      // The touch write needs the stored count; capture it on the key match.
      if (state_ff == ST_FIND_CHK && valid_ff[idx_ff] && rd_data.key == key_ff
          && !found_ff) begin
         vcnt_in = rd_data.count;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_IDLE) else $error("result outside idle");
   assert property (@(posedge clock) disable iff (reset)
      occ_ff == OCC_BITS'($countones(valid_ff))) else $error("occupancy drift");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP) |=> rsp_valid) else $error("lost result");
endmodule

// ----- sim/tb_lfu_cache_table.sv -----
// Self-checking testbench for the LFU cache table: directed table, capacity cases, then random traffic.
// Depends on lfu_pkg and the lfu_cache_table RTL; holds its own model of the cache.
`timescale 1ns / 1ps
module tb_lfu_cache_table;
   import lfu_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 8 * CAPACITY + 20;
   localparam int N_RANDOM       = 1000;

   typedef struct {
      logic                  valid;
      logic [31:0]           key;
      logic [31:0]           value;
      logic [COUNT_BITS-1:0] count;
      int unsigned           rank;
   } slot_type;

   typedef struct {
      logic        hit;
      logic [31:0] read_value;
   } lookup_type;

   typedef struct {
      logic        rtype;
      logic [31:0] key;
      logic [31:0] value;
      logic        typed;
      logic        exp_hit;
      logic [31:0] exp_value;
   } row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_type;
   logic [31:0]         req_key;
   logic signed [31:0]  req_value;
   logic                csr_valid;
   logic                csr_ready;
   logic [CFG_BITS-1:0] csr_data;
   logic                rsp_valid;
   logic                rsp_hit;
   logic signed [31:0]  rsp_read_value;

   slot_type    slots [CAPACITY];
   int unsigned model_occupancy;
   int unsigned model_capacity;
   lookup_type  pending_lookups [$];
   int          mismatches;
   int          idle_cycles;
   logic [31:0] key_pool [8];

   lfu_cache_table i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_key(req_key), .req_value(req_value),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_read_value(rsp_read_value)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      mismatches++;
   endtask

   function automatic void model_touch(input int s);
      int unsigned old;
      old = slots[s].rank;
      for (int i = 0; i < CAPACITY; i++) begin
         if (slots[i].valid && slots[i].rank < old) slots[i].rank++;
      end
      slots[s].rank = 0;
      if (slots[s].count != COUNT_MAX) slots[s].count++;
   endfunction

   function automatic void model_evict();
      int v;
      int unsigned r;
      v = -1;
      for (int i = 0; i < CAPACITY; i++) begin
         if (slots[i].valid && (v < 0 || slots[i].count < slots[v].count ||
             (slots[i].count == slots[v].count && slots[i].rank > slots[v].rank)))
            v = i;
      end
      if (v < 0) return;
      r = slots[v].rank;
      slots[v].valid = 1'b0;
      if (model_occupancy > 0) model_occupancy--;
      for (int i = 0; i < CAPACITY; i++) begin
         if (slots[i].valid && slots[i].rank > r) slots[i].rank--;
      end
   endfunction

   function automatic lookup_type cache_access(input logic rtype, input logic [31:0] key,
                                              input logic [31:0] value);
      lookup_type  res;
      int          s;
      int          f;
      int unsigned lim;
      res.hit = 1'b0;
      res.read_value = '0;
      s = -1;
      lim = (model_capacity < CAPACITY) ? model_capacity : CAPACITY;
      for (int i = 0; i < CAPACITY; i++) begin
         if (s < 0 && slots[i].valid && slots[i].key == key) s = i;
      end
      if (rtype == REQ_GET) begin
         if (s >= 0) begin
            model_touch(s);
            res.hit = 1'b1;
            res.read_value = slots[s].value;
         end
         return res;
      end
      if (lim == 0) return res;
      if (s >= 0) begin
         slots[s].value = value;
         model_touch(s);
         res.hit = 1'b1;
         return res;
      end
      if (model_occupancy >= lim) model_evict();
      f = -1;
      for (int i = 0; i < CAPACITY; i++) begin
         if (f < 0 && !slots[i].valid) f = i;
      end
      if (f < 0) return res;
      for (int i = 0; i < CAPACITY; i++) begin
         if (slots[i].valid) slots[i].rank++;
      end
      slots[f].valid = 1'b1;
      slots[f].key = key;
      slots[f].value = value;
      slots[f].count = 1;
      slots[f].rank = 0;
      model_occupancy++;
      return res;
   endfunction

   task automatic random_gap();
      int n;
      if ($urandom_range(0, 2) == 0) n = 0;
      else if ($urandom_range(0, 19) == 0) n = $urandom_range(20, 150);
      else n = $urandom_range(1, 4);
      repeat (n) @(posedge clock);
   endtask

   task automatic send_request(input logic rtype, input logic [31:0] key,
                               input logic [31:0] value, input logic typed,
                               input logic exp_hit, input logic [31:0] exp_value);
      lookup_type res;
      start    <= 1'b1;
      req_type <= rtype;
      req_key  <= key;
      req_value <= value;
      do @(posedge clock); while (busy);
      start <= 1'b0;
      res = cache_access(rtype, key, value);
      if (typed) begin
         res.hit = exp_hit;
         res.read_value = exp_value;
      end
      pending_lookups.push_back(res);
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input int unsigned cap);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= cap[CFG_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      model_capacity = cap;
   endtask

   task automatic random_phase(input int count, input int unsigned cap);
      logic [31:0] key;
      logic [31:0] value;
      write_capacity(cap);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0) key = $urandom();
         else key = key_pool[$urandom_range(0, (cap > 6) ? 7 : 4)];
         value = $urandom();
         send_request(1'($urandom_range(0, 1)), key, value, 1'b0, 1'b0, '0);
         random_gap();
      end
   endtask

   always @(posedge clock) begin
      lookup_type want;
      if (!reset && rsp_valid) begin
         if (pending_lookups.size() == 0) begin
            report_mismatch("result beat with no request outstanding",
                            {31'b0, rsp_hit}, '0);
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_hit !== want.hit)
               report_mismatch("hit", {31'b0, rsp_hit}, {31'b0, want.hit});
            if (rsp_read_value !== want.read_value)
               report_mismatch("read_value", rsp_read_value, want.read_value);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      row_type rows [$];
      reset = 1'b1;
      start = 1'b0;
      req_type = REQ_GET;
      req_key = '0;
      req_value = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      mismatches = 0;
      idle_cycles = 0;
      model_capacity = 16;
      model_occupancy = 0;
      for (int i = 0; i < CAPACITY; i++) slots[i] = '{1'b0, '0, '0, '0, 0};
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;

      rows = '{
         '{REQ_GET, 32'h0000_0000, 32'h0,          1'b1, 1'b0, 32'h0},
         '{REQ_PUT, 32'h0000_0000, 32'h8000_0000,  1'b1, 1'b0, 32'h0},
         '{REQ_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF,  1'b1, 1'b0, 32'h0},
         '{REQ_GET, 32'h0000_0000, 32'h1234_5678,  1'b1, 1'b1, 32'h8000_0000},
         '{REQ_GET, 32'hFFFF_FFFF, 32'h0,          1'b1, 1'b1, 32'h7FFF_FFFF},
         '{REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF,  1'b1, 1'b1, 32'h0},
         '{REQ_GET, 32'hFFFF_FFFF, 32'h0,          1'b1, 1'b1, 32'hFFFF_FFFF},
         '{REQ_GET, 32'hA5A5_5A5A, 32'h0,          1'b1, 1'b0, 32'h0},
         '{REQ_PUT, 32'h5555_AAAA, 32'hAAAA_5555,  1'b0, 1'b0, 32'h0}
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i])
         send_request(rows[i].rtype, rows[i].key, rows[i].value, rows[i].typed,
                      rows[i].exp_hit, rows[i].exp_value);
      // Overfill a small cache so that the entry with the lowest count is evicted.
      write_capacity(3);
      for (int k = 0; k < 8; k++)
         send_request(k[0], 32'h100 + (k % 5), $urandom(), 1'b0, 1'b0, '0);
      write_capacity(0);
      send_request(REQ_PUT, 32'h200, 32'h1, 1'b1, 1'b0, 32'h0);
      send_request(REQ_GET, 32'h200, 32'h0, 1'b1, 1'b0, 32'h0);
      write_capacity(31);
      send_request(REQ_GET, 32'h104, 32'h0, 1'b0, 1'b0, '0);

      random_phase(250, 16);
      random_phase(150, 4);
      random_phase(80, 0);
      random_phase(150, 31);
      random_phase(200, 1);
      random_phase(170, $urandom_range(2, 15));

      wait_drained();
      if (mismatches == 0 && pending_lookups.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

// ----- files.f -----
rtl/core/lfu_pkg.sv
rtl/core/lfu_entry_ram.sv
rtl/core/lfu_cache_table.sv
sim/tb_lfu_cache_table.sv
